// ----- hw/rtl/spatial_chunk_hash_entity_map_top_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the spatial chunk map
// Concurrent assertion wrappers that compile away in synthesis.
// ---------------------------------------------------------------------------
`ifndef SPATIAL_CHUNK_HASH_ENTITY_MAP_TOP_ASSERT_SVH
`define SPATIAL_CHUNK_HASH_ENTITY_MAP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define SCEM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define SCEM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCEM_ASSERT(lbl, prop, msg)
`define SCEM_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- hw/rtl/scem_pkg.sv -----
// ---------------------------------------------------------------------------
// scem_pkg
// Shared types and default sizes of the spatial chunk map.
// ---------------------------------------------------------------------------
package scem_pkg;

  localparam int SCEM_HASH_SLOTS      = 4096;
  localparam int SCEM_OVERFLOW_CHUNKS = 1024;
  localparam int SCEM_SPARE_BLOCKS    = 4096;
  localparam int SCEM_ENTRIES_PER_BLK = 16;
  localparam int SCEM_ENTITY_BITS     = 16;

  localparam int SCEM_COORD_W = 26;
  localparam int SCEM_INDEX_W = 16;

  typedef enum logic [1:0] {
    ST_APPLIED = 2'd0,
    ST_SAME    = 2'd1,
    ST_CPOOL   = 2'd2,
    ST_BPOOL   = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_HASH, S_LK_CHK, S_NMETA,
    S_TB_META, S_TB_SCAN, S_RM, S_RM_WR, S_AB_META, S_COPY, S_AB_FREE,
    S_INS, S_CLAIM, S_IN_META, S_SP_FREE, S_SP_SET, S_SP_LINK, S_DONE
  } state_t;

endpackage

// ----- hw/rtl/spatial_chunk_hash_entity_map_top.sv -----
// ---------------------------------------------------------------------------
// spatial_chunk_hash_entity_map_top
// Moves one entity between 3-D chunks held in a chained hash table.
// ---------------------------------------------------------------------------
// Usage: drive the in_ fields and raise start; the item is taken at a clock
// edge where start is high and busy is low. busy stays high until the result
// has been shown. Exactly one result follows each item: out_valid is high for
// a single cycle with out_status, out_removed and out_placed. The receiver
// cannot hold results off, so nothing ever backs up into the block.
// The time an item takes depends on the tables: it grows with each chunk
// visited on each hash chain, with each entity block visited and each entry
// scanned during removal, and with each block copy (absorbing an emptied
// first block, or spilling a full one). One item is in flight at a time.
// After reset the block sweeps the chunk memory, clearing the used marks one
// entry a cycle over all HASH_SLOTS + OVERFLOW_CHUNKS entries, with busy high.
// State sits in three RAMs: chunk records (used, key, chain link), block
// headers (fill, link) and block entries. A sequencer reads, modifies and
// writes them back.
// ---------------------------------------------------------------------------
`include "spatial_chunk_hash_entity_map_top_assert.svh"

module spatial_chunk_hash_entity_map_top
  import scem_pkg::*;
#(
  parameter int HASH_SLOTS        = SCEM_HASH_SLOTS,
  parameter int OVERFLOW_CHUNKS   = SCEM_OVERFLOW_CHUNKS,
  parameter int SPARE_BLOCKS      = SCEM_SPARE_BLOCKS,
  parameter int ENTRIES_PER_BLOCK = SCEM_ENTRIES_PER_BLK,
  parameter int ENTITY_BITS       = SCEM_ENTITY_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_old_valid,
  input  logic [SCEM_COORD_W-1:0] in_old_chunk_x,
  input  logic [SCEM_COORD_W-1:0] in_old_chunk_y,
  input  logic [SCEM_COORD_W-1:0] in_old_chunk_z,
  input  logic                    in_new_valid,
  input  logic [SCEM_COORD_W-1:0] in_new_chunk_x,
  input  logic [SCEM_COORD_W-1:0] in_new_chunk_y,
  input  logic [SCEM_COORD_W-1:0] in_new_chunk_z,
  input  logic [SCEM_INDEX_W-1:0] in_entity_index,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic                    out_removed,
  output logic                    out_placed
);

  localparam int CC  = HASH_SLOTS + OVERFLOW_CHUNKS;
  localparam int BC  = CC + SPARE_BLOCKS;
  localparam int EPB = ENTRIES_PER_BLOCK;
  localparam int SW  = $clog2(HASH_SLOTS);
  localparam int CAW = $clog2(CC);
  localparam int BW  = $clog2(BC + 1);
  localparam int BAW = $clog2(BC);
  localparam int FW  = $clog2(EPB + 1);
  localparam int EAW = $clog2(BC * EPB);
  localparam int OVW = $clog2(OVERFLOW_CHUNKS + 1);
  localparam int SPW = $clog2(SPARE_BLOCKS + 1);
  localparam int CW  = SCEM_COORD_W;
  localparam int CWW = 1 + 3 * CW + CAW;
  localparam int MW  = FW + BW;
  localparam int EW  = ENTITY_BITS;

  localparam logic [BW-1:0] NIL = BW'(BC);

  // Chunk record layout: used, key x, key y, key z, chain link.
  localparam int KZ_LO = CAW;
  localparam int KY_LO = CAW + CW;
  localparam int KX_LO = CAW + 2 * CW;

  function automatic logic [EAW-1:0] eaddr(input logic [BAW-1:0] blk,
                                           input logic [FW-1:0] i);
    return EAW'(EAW'(blk) * EAW'(EPB)) + EAW'(i);
  endfunction

  state_t state_r, state_nxt, ret_r, ret_nxt;

  logic          ov_r, nv_r, phase_old_r, home_r, slot_used_r, nc_found_r, pend_r, first_blk_r;
  logic          ov_nxt, nv_nxt, phase_old_nxt, home_nxt, slot_used_nxt, nc_found_nxt;
  logic          pend_nxt, first_blk_nxt;
  logic [CW-1:0] ox_r, oy_r, oz_r, nx_r, ny_r, nz_r;
  logic [CW-1:0] ox_nxt, oy_nxt, oz_nxt, nx_nxt, ny_nxt, nz_nxt;
  logic [EW-1:0] e_r, e_nxt;
  logic [CAW-1:0] cur_r, cur_nxt, nc_r, nc_nxt, tail_r, tail_nxt, clr_r, clr_nxt;
  logic [CWW-1:0] tailw_r, tailw_nxt;
  logic [OVW-1:0] ovf_r, ovf_nxt;
  logic [SPW-1:0] spare_r, spare_nxt;
  logic [BW-1:0]  fhead_r, fhead_nxt, b_r, b_nxt, flink_r, flink_nxt, blink_r, blink_nxt;
  logic [BW-1:0]  ncl_r, ncl_nxt;
  logic [BAW-1:0] first_r, first_nxt, nb_r, nb_nxt, sb_r, sb_nxt, src_r, src_nxt;
  logic [BAW-1:0] dst_r, dst_nxt;
  logic [FW-1:0]  ffill_r, ffill_nxt, n_r, n_nxt, idx_r, idx_nxt, pidx_r, pidx_nxt;
  logic [FW-1:0]  fm1_r, fm1_nxt, nbfill_r, nbfill_nxt, cnt_r, cnt_nxt;
  status_t        status_r, status_nxt;
  logic           removed_r, removed_nxt, placed_r, placed_nxt;

  // Memory ports.
  logic           c_we, m_we, e_we;
  logic [CAW-1:0] c_waddr, c_raddr;
  logic [CWW-1:0] c_wdata, c_rdata;
  logic [BAW-1:0] m_waddr, m_raddr;
  logic [MW-1:0]  m_wdata, m_rdata;
  logic [EAW-1:0] e_waddr, e_raddr;
  logic [EW-1:0]  e_wdata, e_rdata;

  scem_ram #(.WIDTH(CWW), .DEPTH(CC)) u_chunk_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  scem_ram #(.WIDTH(MW), .DEPTH(BC)) u_meta_ram (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  scem_ram #(.WIDTH(EW), .DEPTH(BC * EPB)) u_entry_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  // The hash unit looks at whichever chunk the walk is after.
  logic [SW-1:0] hash_slot;

  scem_hash #(.SW(SW)) u_hash (
    .x(phase_old_r ? ox_r : nx_r),
    .y(phase_old_r ? oy_r : ny_r),
    .z(phase_old_r ? oz_r : nz_r),
    .slot(hash_slot)
  );

  // Decisions shared by the next-state and datapath logic.
  logic           c_used, key_hit, miss_home, link_end, lk_found, lk_miss, su, pool2;
  logic [CAW-1:0] c_link;
  logic [FW-1:0]  m_fill, m_fillc;
  logic [BW-1:0]  m_link;
  logic           full3, scan_hit, same, m_full;
  logic [31:0]    ent32;

  always_comb begin
    c_used    = c_rdata[CWW-1];
    c_link    = c_rdata[CAW-1:0];
    key_hit   = phase_old_r ?
                (c_rdata[KX_LO +: CW] == ox_r && c_rdata[KY_LO +: CW] == oy_r &&
                 c_rdata[KZ_LO +: CW] == oz_r) :
                (c_rdata[KX_LO +: CW] == nx_r && c_rdata[KY_LO +: CW] == ny_r &&
                 c_rdata[KZ_LO +: CW] == nz_r);
    miss_home = home_r && !c_used;
    link_end  = (c_link == '0) || ({1'b0, c_link} >= (CAW + 1)'(CC));
    lk_found  = !miss_home && key_hit;
    lk_miss   = miss_home || (!key_hit && link_end);
    su        = home_r ? c_used : slot_used_r;
    pool2     = su && (ovf_r >= OVW'(OVERFLOW_CHUNKS));
    m_fill    = m_rdata[MW-1:BW];
    m_link    = m_rdata[BW-1:0];
    m_full    = m_fill >= FW'(EPB);
    m_fillc   = m_full ? FW'(EPB) : m_fill;
    full3     = m_full && (fhead_r >= NIL) && (spare_r >= SPW'(SPARE_BLOCKS));
    scan_hit  = pend_r && (e_rdata == e_r);
    same      = in_old_valid && in_new_valid && in_old_chunk_x == in_new_chunk_x &&
                in_old_chunk_y == in_new_chunk_y && in_old_chunk_z == in_new_chunk_z;
    ent32     = {16'd0, in_entity_index};
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:   if (clr_r == CAW'(CC - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (start) begin
          if (same || (!in_new_valid && !in_old_valid)) state_nxt = S_DONE;
          else state_nxt = S_HASH;
        end
      end
      S_HASH:    state_nxt = S_LK_CHK;
      S_LK_CHK: begin
        if (!phase_old_r) begin
          if (lk_found) state_nxt = S_NMETA;
          else if (lk_miss) state_nxt = pool2 ? S_DONE : (ov_r ? S_HASH : S_INS);
        end else begin
          if (lk_found) state_nxt = S_TB_META;
          else if (lk_miss) state_nxt = S_INS;
        end
      end
      S_NMETA:   state_nxt = full3 ? S_DONE : (ov_r ? S_HASH : S_INS);
      S_TB_META: begin
        if (m_fillc != '0) state_nxt = S_TB_SCAN;
        else state_nxt = (m_link >= NIL) ? S_INS : S_TB_META;
      end
      S_TB_SCAN: begin
        if (scan_hit) state_nxt = S_RM;
        else if (idx_r >= n_r) state_nxt = (blink_r >= NIL) ? S_INS : S_TB_META;
      end
      S_RM:      state_nxt = (ffill_r == '0) ? S_INS : S_RM_WR;
      S_RM_WR:   state_nxt = (fm1_r == '0 && flink_r < NIL) ? S_AB_META : S_INS;
      S_AB_META: state_nxt = S_COPY;
      S_COPY:    if (cnt_r == FW'(EPB)) state_nxt = ret_r;
      S_AB_FREE: state_nxt = S_INS;
      S_INS:     state_nxt = !nv_r ? S_DONE : (nc_found_r ? S_IN_META : S_CLAIM);
      S_CLAIM:   state_nxt = S_DONE;
      S_IN_META: begin
        if (m_full) state_nxt = (fhead_r < NIL) ? S_SP_FREE : S_SP_SET;
        else state_nxt = S_DONE;
      end
      S_SP_FREE: state_nxt = S_SP_SET;
      S_SP_SET:  state_nxt = S_COPY;
      S_SP_LINK: state_nxt = S_DONE;
      S_DONE:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    ret_nxt = ret_r;
    ov_nxt = ov_r; nv_nxt = nv_r; phase_old_nxt = phase_old_r; home_nxt = home_r;
    slot_used_nxt = slot_used_r; nc_found_nxt = nc_found_r; pend_nxt = pend_r;
    first_blk_nxt = first_blk_r;
    ox_nxt = ox_r; oy_nxt = oy_r; oz_nxt = oz_r; nx_nxt = nx_r; ny_nxt = ny_r; nz_nxt = nz_r;
    e_nxt = e_r; cur_nxt = cur_r; nc_nxt = nc_r; tail_nxt = tail_r; clr_nxt = clr_r;
    tailw_nxt = tailw_r; ovf_nxt = ovf_r; spare_nxt = spare_r; fhead_nxt = fhead_r;
    b_nxt = b_r; flink_nxt = flink_r; blink_nxt = blink_r; ncl_nxt = ncl_r;
    first_nxt = first_r; nb_nxt = nb_r; sb_nxt = sb_r; src_nxt = src_r; dst_nxt = dst_r;
    ffill_nxt = ffill_r; n_nxt = n_r; idx_nxt = idx_r; pidx_nxt = pidx_r; fm1_nxt = fm1_r;
    nbfill_nxt = nbfill_r; cnt_nxt = cnt_r;
    status_nxt = status_r; removed_nxt = removed_r; placed_nxt = placed_r;
    c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_raddr = '0;
    m_we = 1'b0; m_waddr = '0; m_wdata = '0; m_raddr = '0;
    e_we = 1'b0; e_waddr = '0; e_wdata = '0; e_raddr = '0;
    case (state_r)
      S_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = clr_r;
        clr_nxt = clr_r + 1'b1;
      end
      S_IDLE: begin
        if (start) begin
          ov_nxt = in_old_valid; nv_nxt = in_new_valid;
          ox_nxt = in_old_chunk_x; oy_nxt = in_old_chunk_y; oz_nxt = in_old_chunk_z;
          nx_nxt = in_new_chunk_x; ny_nxt = in_new_chunk_y; nz_nxt = in_new_chunk_z;
          e_nxt  = ent32[EW-1:0];
          phase_old_nxt = !in_new_valid;
          nc_found_nxt = 1'b0; slot_used_nxt = 1'b0;
          status_nxt = same ? ST_SAME : ST_APPLIED;
          removed_nxt = 1'b0; placed_nxt = 1'b0;
        end
      end
      S_HASH: begin
        c_raddr  = CAW'(hash_slot);
        cur_nxt  = CAW'(hash_slot);
        home_nxt = 1'b1;
        if (!phase_old_r) tail_nxt = CAW'(hash_slot);
      end
      S_LK_CHK: begin
        home_nxt = 1'b0;
        if (!phase_old_r && home_r) slot_used_nxt = c_used;
        if (lk_found) begin
          m_raddr = BAW'(cur_r);
          if (!phase_old_r) begin
            nc_found_nxt = 1'b1;
            nc_nxt = cur_r;
          end else begin
            b_nxt = BW'(cur_r);
            first_nxt = BAW'(cur_r);
            first_blk_nxt = 1'b1;
          end
        end else if (lk_miss) begin
          if (!phase_old_r) begin
            // The last chunk seen on the chain takes the new link.
            tail_nxt  = cur_r;
            tailw_nxt = c_rdata;
            if (pool2) status_nxt = ST_CPOOL;
            else if (ov_r) phase_old_nxt = 1'b1;
          end
        end else begin
          if (!phase_old_r) begin
            tail_nxt  = cur_r;
            tailw_nxt = c_rdata;
          end
          cur_nxt = c_link;
          c_raddr = c_link;
        end
      end
      S_NMETA: begin
        if (full3) status_nxt = ST_BPOOL;
        else if (ov_r) phase_old_nxt = 1'b1;
      end
      S_TB_META: begin
        if (first_blk_r) begin
          ffill_nxt = m_fillc;
          flink_nxt = m_link;
        end
        first_blk_nxt = 1'b0;
        n_nxt = m_fillc; blink_nxt = m_link; idx_nxt = '0; pend_nxt = 1'b0;
        if (m_fillc == '0) begin
          b_nxt = m_link;
          m_raddr = m_link[BAW-1:0];
        end
      end
      S_TB_SCAN: begin
        if (scan_hit) begin
          pend_nxt = 1'b0;
        end else if (idx_r >= n_r) begin
          pend_nxt = 1'b0;
          b_nxt = blink_r;
          m_raddr = blink_r[BAW-1:0];
        end else begin
          e_raddr = eaddr(b_r[BAW-1:0], idx_r);
          pend_nxt = 1'b1;
          pidx_nxt = idx_r;
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_RM: begin
        // The last entry of the first block fills the hole.
        if (ffill_r == '0) begin
          removed_nxt = 1'b1;
        end else begin
          fm1_nxt = ffill_r - 1'b1;
          e_raddr = eaddr(first_r, ffill_r - 1'b1);
        end
      end
      S_RM_WR: begin
        e_we = 1'b1;
        e_waddr = eaddr(b_r[BAW-1:0], pidx_r);
        e_wdata = e_rdata;
        m_we = 1'b1;
        m_waddr = first_r;
        m_wdata = {fm1_r, flink_r};
        removed_nxt = 1'b1;
        if (fm1_r == '0 && flink_r < NIL) begin
          nb_nxt = flink_r[BAW-1:0];
          m_raddr = flink_r[BAW-1:0];
        end
      end
      S_AB_META: begin
        // The emptied first block takes over its successor's header.
        m_we = 1'b1;
        m_waddr = first_r;
        m_wdata = m_rdata;
        nbfill_nxt = m_fill;
        src_nxt = nb_r; dst_nxt = first_r; cnt_nxt = '0;
        ret_nxt = S_AB_FREE;
      end
      S_COPY: begin
        if (cnt_r < FW'(EPB)) e_raddr = eaddr(src_r, cnt_r);
        if (cnt_r != '0) begin
          e_we = 1'b1;
          e_waddr = eaddr(dst_r, cnt_r - 1'b1);
          e_wdata = e_rdata;
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      S_AB_FREE: begin
        m_we = 1'b1;
        m_waddr = nb_r;
        m_wdata = {nbfill_r, fhead_r};
        fhead_nxt = BW'(nb_r);
      end
      S_INS: begin
        if (nv_r && !nc_found_r) begin
          if (slot_used_r) begin
            nc_nxt = CAW'(HASH_SLOTS) + CAW'(ovf_r);
            ovf_nxt = ovf_r + 1'b1;
            c_we = 1'b1;
            c_waddr = tail_r;
            c_wdata = {tailw_r[CWW-1:CAW], CAW'(HASH_SLOTS) + CAW'(ovf_r)};
          end else begin
            nc_nxt = tail_r;
          end
        end else if (nv_r) begin
          m_raddr = BAW'(nc_r);
        end
      end
      S_CLAIM: begin
        c_we = 1'b1;
        c_waddr = nc_r;
        c_wdata = {1'b1, nx_r, ny_r, nz_r, {CAW{1'b0}}};
        m_we = 1'b1;
        m_waddr = BAW'(nc_r);
        m_wdata = {FW'(1), NIL};
        e_we = 1'b1;
        e_waddr = eaddr(BAW'(nc_r), '0);
        e_wdata = e_r;
        placed_nxt = 1'b1;
      end
      S_IN_META: begin
        ncl_nxt = m_link;
        if (m_full) begin
          if (fhead_r < NIL) begin
            sb_nxt = fhead_r[BAW-1:0];
            m_raddr = fhead_r[BAW-1:0];
          end else begin
            sb_nxt = BAW'(CC) + BAW'(spare_r);
            spare_nxt = spare_r + 1'b1;
          end
        end else begin
          e_we = 1'b1;
          e_waddr = eaddr(BAW'(nc_r), m_fill);
          e_wdata = e_r;
          m_we = 1'b1;
          m_waddr = BAW'(nc_r);
          m_wdata = {m_fill + 1'b1, m_link};
          placed_nxt = 1'b1;
        end
      end
      S_SP_FREE: fhead_nxt = m_link;
      S_SP_SET: begin
        // The full first block moves to the spare block behind it.
        m_we = 1'b1;
        m_waddr = sb_r;
        m_wdata = {FW'(EPB), ncl_r};
        src_nxt = BAW'(nc_r); dst_nxt = sb_r; cnt_nxt = '0;
        ret_nxt = S_SP_LINK;
      end
      S_SP_LINK: begin
        m_we = 1'b1;
        m_waddr = BAW'(nc_r);
        m_wdata = {FW'(1), BW'(sb_r)};
        e_we = 1'b1;
        e_waddr = eaddr(BAW'(nc_r), '0);
        e_wdata = e_r;
        placed_nxt = 1'b1;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      ovf_r   <= '0;
      spare_r <= '0;
      fhead_r <= NIL;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ovf_r   <= ovf_nxt;
      spare_r <= spare_nxt;
      fhead_r <= fhead_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r <= ret_nxt;
    ov_r <= ov_nxt; nv_r <= nv_nxt; phase_old_r <= phase_old_nxt; home_r <= home_nxt;
    slot_used_r <= slot_used_nxt; nc_found_r <= nc_found_nxt; pend_r <= pend_nxt;
    first_blk_r <= first_blk_nxt;
    ox_r <= ox_nxt; oy_r <= oy_nxt; oz_r <= oz_nxt;
    nx_r <= nx_nxt; ny_r <= ny_nxt; nz_r <= nz_nxt;
    e_r <= e_nxt; cur_r <= cur_nxt; nc_r <= nc_nxt; tail_r <= tail_nxt; tailw_r <= tailw_nxt;
    b_r <= b_nxt; flink_r <= flink_nxt; blink_r <= blink_nxt; ncl_r <= ncl_nxt;
    first_r <= first_nxt; nb_r <= nb_nxt; sb_r <= sb_nxt; src_r <= src_nxt; dst_r <= dst_nxt;
    ffill_r <= ffill_nxt; n_r <= n_nxt; idx_r <= idx_nxt; pidx_r <= pidx_nxt;
    fm1_r <= fm1_nxt; nbfill_r <= nbfill_nxt; cnt_r <= cnt_nxt;
    status_r <= status_nxt; removed_r <= removed_nxt; placed_r <= placed_nxt;
  end

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = (state_r == S_DONE);
  assign out_status  = status_r;
  assign out_removed = removed_r;
  assign out_placed  = placed_r;

  // An accepted item holds the block until its result has been shown.
  `SCEM_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted item did not raise busy")
  // A result strobe lasts one cycle.
  `SCEM_ASSERT(a_single_strobe, out_valid |=> !out_valid, "result strobe held")
  // A pool-full result leaves the tables untouched.
  `SCEM_ASSERT(a_pool_noop,
    out_valid && (out_status == ST_CPOOL || out_status == ST_BPOOL) |-> !out_removed && !out_placed,
    "pool-full result reports a change")
  // Reset starts the clearing sweep.
  `SCEM_ASSERT_RST(a_reset_clear, !rst_n |=> busy, "not busy after reset")

endmodule

// ----- hw/rtl/scem_ram.sv -----
// ---------------------------------------------------------------------------
// scem_ram
// Generic single-write, single-read RAM with a registered read.
// ---------------------------------------------------------------------------
module scem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/scem_hash.sv -----
// ---------------------------------------------------------------------------
// scem_hash
// Home slot of a chunk: 19x + 7y + 3z kept to the slot index bits.
// ---------------------------------------------------------------------------
module scem_hash
  import scem_pkg::*;
#(
  parameter int SW = 12
) (
  input  logic [SCEM_COORD_W-1:0] x,
  input  logic [SCEM_COORD_W-1:0] y,
  input  logic [SCEM_COORD_W-1:0] z,
  output logic [SW-1:0]           slot
);

  logic [SW-1:0] xs, ys, zs, tx, ty, tz;

  // Only the low bits survive the mask, so the sign extension never matters.
  assign xs = x[SW-1:0];
  assign ys = y[SW-1:0];
  assign zs = z[SW-1:0];
  assign tx = (xs << 4) + (xs << 1) + xs;
  assign ty = (ys << 3) - ys;
  assign tz = (zs << 1) + zs;
  assign slot = tx + ty + tz;

endmodule

// ----- bench/spatial_chunk_hash_entity_map_checker.sv -----
// ---------------------------------------------------------------------------
// spatial_chunk_hash_entity_map_checker
// Watches the item and result channels of the chunk map, keeps its own copy
// of the chunk and block tables and checks each result as it appears.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module spatial_chunk_hash_entity_map_checker
  import scem_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic                    in_old_valid,
  input  logic [SCEM_COORD_W-1:0] in_old_chunk_x,
  input  logic [SCEM_COORD_W-1:0] in_old_chunk_y,
  input  logic [SCEM_COORD_W-1:0] in_old_chunk_z,
  input  logic                    in_new_valid,
  input  logic [SCEM_COORD_W-1:0] in_new_chunk_x,
  input  logic [SCEM_COORD_W-1:0] in_new_chunk_y,
  input  logic [SCEM_COORD_W-1:0] in_new_chunk_z,
  input  logic [SCEM_INDEX_W-1:0] in_entity_index,
  input  logic                    out_valid,
  input  logic [1:0]              out_status,
  input  logic                    out_removed,
  input  logic                    out_placed,
  output int                      pending,
  output int                      errors
);

  localparam int CHUNKS = SCEM_HASH_SLOTS + SCEM_OVERFLOW_CHUNKS;
  localparam int BLOCKS = CHUNKS + SCEM_SPARE_BLOCKS;
  localparam int EPB    = SCEM_ENTRIES_PER_BLK;
  localparam int NIL    = BLOCKS;
  localparam int NONE   = CHUNKS;

  typedef logic [SCEM_COORD_W-1:0] coord_t;

  typedef struct packed {
    status_t status;
    logic    removed;
    logic    placed;
  } move_result_t;

  bit     used [CHUNKS];
  coord_t key_x [CHUNKS];
  coord_t key_y [CHUNKS];
  coord_t key_z [CHUNKS];
  int     chain [CHUNKS];
  int     ovf_taken;
  int     fill [BLOCKS];
  int     blink [BLOCKS];
  logic [SCEM_INDEX_W-1:0] ents [BLOCKS*EPB];
  int     free_head;
  int     spare_taken;

  move_result_t awaited_moves[$];

  assign pending = awaited_moves.size();

  initial begin
    errors = 0;
    for (int i = 0; i < CHUNKS; i++) begin
      used[i] = 0;
      chain[i] = 0;
    end
    for (int i = 0; i < BLOCKS; i++) begin
      fill[i] = 0;
      blink[i] = NIL;
    end
    ovf_taken = 0;
    free_head = NIL;
    spare_taken = 0;
  end

  // Coordinates are sign-extended to 32 bits before the weighted sum wraps.
  function automatic int home_of(coord_t x, coord_t y, coord_t z);
    logic [31:0] h;
    h = 32'd19 * 32'(signed'(x)) + 32'd7 * 32'(signed'(y)) + 32'd3 * 32'(signed'(z));
    return int'(h & (SCEM_HASH_SLOTS - 1));
  endfunction

  function automatic int find_chunk(coord_t x, coord_t y, coord_t z, output int tail);
    int c;
    c = home_of(x, y, z);
    tail = c;
    if (!used[c]) return NONE;
    for (int n = 0; n <= SCEM_OVERFLOW_CHUNKS; n++) begin
      if (key_x[c] == x && key_y[c] == y && key_z[c] == z) return c;
      tail = c;
      if (chain[c] == 0 || chain[c] >= CHUNKS) return NONE;
      c = chain[c];
    end
    return NONE;
  endfunction

  function automatic bit remove_entity(int first, logic [SCEM_INDEX_W-1:0] e);
    int b;
    int n;
    int f;
    int nb;
    b = first;
    for (int steps = 0; steps < BLOCKS && b < BLOCKS; steps++) begin
      n = (fill[b] > EPB) ? EPB : fill[b];
      for (int i = 0; i < n; i++) begin
        if (ents[b*EPB + i] == e) begin
          f = (fill[first] > EPB) ? EPB : fill[first];
          if (f > 0) begin
            f--;
            ents[b*EPB + i] = ents[first*EPB + f];
            fill[first] = f;
            // An emptied first block pulls in its successor.
            if (f == 0 && blink[first] < BLOCKS) begin
              nb = blink[first];
              fill[first] = fill[nb];
              blink[first] = blink[nb];
              for (int k = 0; k < EPB; k++) ents[first*EPB + k] = ents[nb*EPB + k];
              blink[nb] = free_head;
              free_head = nb;
            end
          end
          return 1;
        end
      end
      b = blink[b];
    end
    return 0;
  endfunction

  function automatic move_result_t apply_move();
    move_result_t r;
    int nc;
    int tail;
    int slot;
    int oc;
    int sb;
    r.status = ST_APPLIED;
    r.removed = 0;
    r.placed = 0;
    nc = NONE;
    tail = 0;
    slot = 0;
    if (in_old_valid && in_new_valid && in_old_chunk_x == in_new_chunk_x &&
        in_old_chunk_y == in_new_chunk_y && in_old_chunk_z == in_new_chunk_z) begin
      r.status = ST_SAME;
      return r;
    end
    if (in_new_valid) begin
      slot = home_of(in_new_chunk_x, in_new_chunk_y, in_new_chunk_z);
      nc = find_chunk(in_new_chunk_x, in_new_chunk_y, in_new_chunk_z, tail);
      if (nc == NONE && used[slot] && ovf_taken >= SCEM_OVERFLOW_CHUNKS)
        r.status = ST_CPOOL;
      else if (nc != NONE && fill[nc] >= EPB && free_head >= BLOCKS &&
               spare_taken >= SCEM_SPARE_BLOCKS)
        r.status = ST_BPOOL;
    end
    if (r.status != ST_APPLIED) return r;
    if (in_old_valid) begin
      oc = find_chunk(in_old_chunk_x, in_old_chunk_y, in_old_chunk_z, tail);
      if (oc != NONE && remove_entity(oc, in_entity_index)) r.removed = 1;
    end
    if (in_new_valid) begin
      if (nc == NONE) begin
        // The lookup is repeated since the removal may not touch chunks, but
        // the tail must be the one of the new chunk's chain.
        void'(find_chunk(in_new_chunk_x, in_new_chunk_y, in_new_chunk_z, tail));
        if (!used[slot]) begin
          nc = slot;
        end else begin
          nc = SCEM_HASH_SLOTS + ovf_taken;
          ovf_taken++;
          chain[tail] = nc;
        end
        used[nc] = 1;
        key_x[nc] = in_new_chunk_x;
        key_y[nc] = in_new_chunk_y;
        key_z[nc] = in_new_chunk_z;
        chain[nc] = 0;
        fill[nc] = 0;
        blink[nc] = NIL;
      end
      if (fill[nc] >= EPB) begin
        if (free_head < BLOCKS) begin
          sb = free_head;
          free_head = blink[sb];
        end else begin
          sb = CHUNKS + spare_taken;
          spare_taken++;
        end
        fill[sb] = EPB;
        blink[sb] = blink[nc];
        for (int k = 0; k < EPB; k++) ents[sb*EPB + k] = ents[nc*EPB + k];
        blink[nc] = sb;
        fill[nc] = 0;
      end
      ents[nc*EPB + fill[nc]] = in_entity_index;
      fill[nc]++;
      r.placed = 1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    move_result_t want;
    if (rst_n) begin
      if (start && !busy) awaited_moves.push_back(apply_move());
      if (out_valid) begin
        if (awaited_moves.size() == 0) begin
          $error("result with no item outstanding");
          errors++;
        end else begin
          want = awaited_moves.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errors++;
          end
          if (out_removed !== want.removed) begin
            $error("removed: expected %0d, got %0d", want.removed, out_removed);
            errors++;
          end
          if (out_placed !== want.placed) begin
            $error("placed: expected %0d, got %0d", want.placed, out_placed);
            errors++;
          end
        end
      end
    end
  end

endmodule

// ----- bench/spatial_chunk_hash_entity_map_top_test.sv -----
// ---------------------------------------------------------------------------
// spatial_chunk_hash_entity_map_top_test
// Drives entity moves into the chunk map and gives the verdict; a checker
// beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module spatial_chunk_hash_entity_map_top_test;
  import scem_pkg::*;

  typedef logic [SCEM_COORD_W-1:0] coord_t;

  // A few fixed chunks that entities wander between. Three pairs share a home
  // slot so that chains form, and the first pair is the extreme corners.
  localparam int ROOMS = 8;
  localparam int CROWD = 48;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_old_valid;
  coord_t in_old_chunk_x, in_old_chunk_y, in_old_chunk_z;
  logic in_new_valid;
  coord_t in_new_chunk_x, in_new_chunk_y, in_new_chunk_z;
  logic [SCEM_INDEX_W-1:0] in_entity_index;
  logic out_valid;
  logic [1:0] out_status;
  logic out_removed;
  logic out_placed;
  int pending;
  int errors;
  int cycles;
  bit quiet;

  coord_t room_x [ROOMS];
  coord_t room_y [ROOMS];
  coord_t room_z [ROOMS];
  int     where_is [CROWD];

  spatial_chunk_hash_entity_map_top i_dut (
    .clk, .rst_n, .start, .busy,
    .in_old_valid, .in_old_chunk_x, .in_old_chunk_y, .in_old_chunk_z,
    .in_new_valid, .in_new_chunk_x, .in_new_chunk_y, .in_new_chunk_z,
    .in_entity_index,
    .out_valid, .out_status, .out_removed, .out_placed
  );

  spatial_chunk_hash_entity_map_checker i_checker (
    .clk, .rst_n, .start, .busy,
    .in_old_valid, .in_old_chunk_x, .in_old_chunk_y, .in_old_chunk_z,
    .in_new_valid, .in_new_chunk_x, .in_new_chunk_y, .in_new_chunk_z,
    .in_entity_index,
    .out_valid, .out_status, .out_removed, .out_placed,
    .pending, .errors
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // The run is bounded well above the slowest correct run: the clearing
  // sweep, then each item walking a long chain and several block copies.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // A coordinate triple whose home slot is the given one: the low twelve
  // bits of z are chosen so that 19x + 7y + 3z wraps onto the slot.
  // 2731 is the inverse of 3 modulo 4096.
  function automatic void aim_at(int slot, output coord_t x, output coord_t y,
                                 output coord_t z);
    logic [31:0] part;
    logic [11:0] low;
    x = coord_t'($urandom);
    y = coord_t'($urandom);
    part = 32'd19 * 32'(signed'(x)) + 32'd7 * 32'(signed'(y));
    low = 12'(32'd2731 * (32'(slot) - part));
    z = {14'($urandom), low};
  endfunction

  // Offers one item at a falling edge and holds it until it is taken. busy
  // only moves at rising edges, so its value here is the one the next rising
  // edge will see. start stays high when the next item follows at once.
  task automatic move(input logic ov, input coord_t ox, input coord_t oy,
                      input coord_t oz, input logic nv, input coord_t nx,
                      input coord_t ny, input coord_t nz,
                      input logic [SCEM_INDEX_W-1:0] e);
    bit taken;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    start <= 1;
    in_old_valid <= ov;
    in_old_chunk_x <= ox;
    in_old_chunk_y <= oy;
    in_old_chunk_z <= oz;
    in_new_valid <= nv;
    in_new_chunk_x <= nx;
    in_new_chunk_y <= ny;
    in_new_chunk_z <= nz;
    in_entity_index <= e;
    taken = 0;
    while (!taken) begin
      taken = (busy == 0);
      @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // A move between two rooms, or in or out of the map.
  task automatic room_move(int from, int to, logic [SCEM_INDEX_W-1:0] e);
    move(from >= 0, from >= 0 ? room_x[from] : '0, from >= 0 ? room_y[from] : '0,
         from >= 0 ? room_z[from] : '0, to >= 0, to >= 0 ? room_x[to] : '0,
         to >= 0 ? room_y[to] : '0, to >= 0 ? room_z[to] : '0, e);
  endtask

  initial begin
    coord_t ax, ay, az, bx, by, bz;
    int to;
    int who;
    int slot;

    cycles = 0;
    quiet = 0;
    rst_n = 0;
    start = 0;
    in_old_valid = 0;
    in_old_chunk_x = '0;
    in_old_chunk_y = '0;
    in_old_chunk_z = '0;
    in_new_valid = 0;
    in_new_chunk_x = '0;
    in_new_chunk_y = '0;
    in_new_chunk_z = '0;
    in_entity_index = '0;

    room_x[0] = 26'h1FFFFFE; room_y[0] = 26'h1FFFFFE; room_z[0] = 26'h1FFFFFE;
    room_x[1] = 26'h2000002; room_y[1] = 26'h2000002; room_z[1] = 26'h2000002;
    for (int i = 2; i < ROOMS; i++) aim_at(100 + i / 2, room_x[i], room_y[i], room_z[i]);
    for (int i = 0; i < CROWD; i++) where_is[i] = -1;

    repeat (8) @(negedge clk);
    rst_n <= 1;

    // Directed part. The very first item is offered during the clearing
    // sweep and must wait for it.
    room_move(-1, 0, 16'h0000);
    room_move(-1, 1, 16'hFFFF);
    room_move(0, 0, 16'h0000);                 // same chunk, skipped
    room_move(1, -1, 16'h1234);                // entity not in the old chunk
    room_move(-1, -1, 16'h0000);               // no old, no new
    room_move(0, 1, 16'h0000);                 // plain move between corners
    room_move(1, -1, 16'hFFFF);                // removal only
    room_move(3, 2, 16'h0001);                 // old chunk never claimed
    room_move(-1, 3, 16'h0001);                // chains behind room 2's slot
    room_move(-1, 3, 16'h0001);                // stored twice
    room_move(3, 2, 16'h0001);                 // takes the first copy
    move(1, 26'h2000000, 26'h1FFFFFF, 26'h0000000, 1, 26'h2000000, 26'h1FFFFFF,
         26'h0000001, 16'h8000);               // out-of-range patterns
    // Fill one chunk past a block to force a spill, then empty it again so
    // the first block absorbs its successor and frees it.
    for (int i = 0; i < 18; i++) room_move(-1, 4, 16'(16'h0100 + i));
    drain();
    for (int i = 0; i < 18; i++) room_move(4, -1, 16'(16'h0100 + i));
    drain();

    // Entities mostly move where they really are; a fifth are noise.
    for (int n = 0; n < 150; n++) begin
      who = $urandom_range(0, CROWD - 1);
      to = ($urandom_range(0, 9) == 0) ? -1 : $urandom_range(0, ROOMS - 1);
      if ($urandom_range(0, 4) == 0) begin
        room_move($urandom_range(0, 2) == 0 ? -1 : $urandom_range(0, ROOMS - 1), to,
                  16'($urandom));
      end else begin
        room_move(where_is[who], to, 16'(who));
        if (!(where_is[who] == to)) where_is[who] = to;
      end
    end
    drain();

    // Many new chunks crowd into sixteen home slots until the overflow pool
    // runs out; later claims there see the chunk pool full.
    for (int n = 0; n < 1120; n++) begin
      if (n > 950) quiet = 1;
      slot = 37 * $urandom_range(0, 15);
      aim_at(slot, bx, by, bz);
      if ($urandom_range(0, 5) == 0) begin
        who = $urandom_range(0, CROWD - 1);
        to = $urandom_range(0, ROOMS - 1);
        ax = room_x[to]; ay = room_y[to]; az = room_z[to];
        move(1, ax, ay, az, 1, bx, by, bz, 16'(who));
      end else begin
        move($urandom_range(0, 3) == 0, coord_t'($urandom), coord_t'($urandom),
             coord_t'($urandom), 1, bx, by, bz, 16'($urandom));
      end
    end

    drain();
    repeat (60) @(negedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
